@@ src/mfrf_pkg.sv @@
// ----------------------------------------------------------------------------
// mfrf_pkg
// Shared constants and types of the flooding relay filter: cache sizing,
// header layout and the command word passed from the front to the back.
// ----------------------------------------------------------------------------
package mfrf_pkg;

    // seen-id cache sizing (2 .. 1024 entries)
    localparam int SEEN_DEPTH = 64;
    localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
    localparam int FILL_W     = $clog2(SEEN_DEPTH + 1);

    // packet header: four id bytes, then ttl
    localparam int         HDR_LEN   = 5;
    localparam int         IDX_W     = 3;
    localparam logic [7:0] TTL_LIMIT = 8'd127;

    // command queue between front and back (power of two)
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

    // one command: a whole header or one payload byte
    typedef struct packed {
        logic        is_hdr;
        logic        op;
        logic        last;
        logic [7:0]  data;
        logic [31:0] id;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ src/mfrf_in_if.sv @@
// ----------------------------------------------------------------------------
// mfrf_in_if
// Input byte channel: valid/ready handshake with one packet byte per beat.
// ----------------------------------------------------------------------------
interface mfrf_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output op, output data_byte, output last, input ready);
    modport sink   (input valid, input op, input data_byte, input last, output ready);
endinterface

@@ src/mfrf_out_if.sv @@
// ----------------------------------------------------------------------------
// mfrf_out_if
// Output byte channel: valid/ready handshake with deliver and relay bytes.
// ----------------------------------------------------------------------------
interface mfrf_out_if;
    logic       valid;
    logic       ready;
    logic       deliver_valid;
    logic [7:0] deliver_byte;
    logic       relay_valid;
    logic [7:0] relay_byte;
    logic       end_of_packet;

    modport source (output valid, output deliver_valid, output deliver_byte,
                    output relay_valid, output relay_byte, output end_of_packet,
                    input ready);
    modport sink   (input valid, input deliver_valid, input deliver_byte,
                    input relay_valid, input relay_byte, input end_of_packet,
                    output ready);
endinterface

@@ src/mfrf_ram.sv @@
// ----------------------------------------------------------------------------
// mfrf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mfrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mfrf_front.sv @@
// ----------------------------------------------------------------------------
// mfrf_front
// Input side: collects the five header bytes, drops short packets and turns
// each packet into one header command followed by payload commands.
// ----------------------------------------------------------------------------
module mfrf_front import mfrf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfrf_in_if.sink       i_in,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic [IDX_W-1:0] r_cnt;
    logic             r_body;
    logic [31:0]      r_id;
    logic             w_beat;
    logic             w_hdr_done;

    assign i_in.ready = !i_q_stat.full;
    assign w_beat     = i_in.valid && i_in.ready;
    assign w_hdr_done = !r_body && (r_cnt == IDX_W'(HDR_LEN - 1));

    // push headers on the ttl byte, payload bytes as they come
    assign o_push     = w_beat && (r_body || w_hdr_done);
    assign o_cmd      = '{is_hdr: !r_body, op: i_in.op, last: i_in.last,
                          data: i_in.data_byte, id: r_id};

    // track header position and packet body
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_body <= 1'b0;
        end else if (w_beat) begin
            if (r_body) begin
                if (i_in.last) begin
                    r_body <= 1'b0;
                end
            end else if (w_hdr_done) begin
                r_cnt  <= '0;
                r_body <= !i_in.last;
            end else if (i_in.last) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
        end
    end

    // shift in id bytes, most significant first
    always_ff @(posedge i_clk) begin
        if (w_beat && !r_body && !w_hdr_done) begin
            r_id <= {r_id[23:0], i_in.data_byte};
        end
    end

endmodule

@@ src/mfrf_queue.sv @@
// ----------------------------------------------------------------------------
// mfrf_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module mfrf_queue import mfrf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wp;
    logic [CMD_AW-1:0] r_rp;
    logic [CMD_CW-1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CMD_CW'(CMD_DEPTH));

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + CMD_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + CMD_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CMD_CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CMD_CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ src/mfrf_back.sv @@
// ----------------------------------------------------------------------------
// mfrf_back
// Execution side: checks the ttl, scans the seen-id cache one entry per
// cycle, inserts new ids, replays the header and passes payload bytes
// through an output register.
// ----------------------------------------------------------------------------
module mfrf_back import mfrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    mfrf_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_REPLAY = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        M_HDR  = 3'b001,
        M_PASS = 3'b010,
        M_DROP = 3'b100
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    logic [31:0]        r_id, n_id;
    logic [7:0]         r_ttl, n_ttl;
    logic               r_local, n_local;
    logic               r_last, n_last;
    logic               r_relay_en, n_relay_en;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [FILL_W-1:0]  r_scan, n_scan;
    logic               r_pend, n_pend;
    logic [SEEN_AW-1:0] r_wptr, n_wptr;
    logic [IDX_W-1:0]   r_idx, n_idx;

    // output register
    logic               r_o_valid;
    logic [7:0]         r_o_dbyte;
    logic               r_o_rvalid;
    logic [7:0]         r_o_rbyte;
    logic               r_o_end;

    logic               w_load_ok;
    logic               w_load;
    logic [7:0]         w_ld_dbyte;
    logic               w_ld_rvalid;
    logic [7:0]         w_ld_rbyte;
    logic               w_ld_end;

    logic               w_we;
    logic               w_re;
    logic [31:0]        w_rdata;
    logic [7:0]         w_rep_byte;
    logic               w_issue;
    logic               w_hit;

    mfrf_ram #(
        .WIDTH (32),
        .DEPTH (SEEN_DEPTH)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (r_id),
        .i_re    (w_re),
        .i_raddr (r_scan[SEEN_AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_load_ok = !r_o_valid || o_out.ready;
    assign w_issue   = (r_scan < r_fill);
    assign w_hit     = r_pend && (w_rdata == r_id);

    // pick the header byte under replay
    always_comb begin
        case (r_idx)
            IDX_W'(0): w_rep_byte = r_id[31:24];
            IDX_W'(1): w_rep_byte = r_id[23:16];
            IDX_W'(2): w_rep_byte = r_id[15:8];
            IDX_W'(3): w_rep_byte = r_id[7:0];
            default:   w_rep_byte = r_ttl;
        endcase
    end

    // decide, scan, insert and emit
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_id        = r_id;
        n_ttl       = r_ttl;
        n_local     = r_local;
        n_last      = r_last;
        n_relay_en  = r_relay_en;
        n_fill      = r_fill;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_wptr      = r_wptr;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_load      = 1'b0;
        w_ld_dbyte  = i_head.data;
        w_ld_rvalid = r_relay_en;
        w_ld_rbyte  = r_relay_en ? i_head.data : 8'h00;
        w_ld_end    = i_head.last;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_head.is_hdr) begin
                        // latch the header; start the lookup, or reject a relayed ttl over the limit
                        o_pop   = 1'b1;
                        n_id    = i_head.id;
                        n_ttl   = i_head.data;
                        n_local = i_head.op;
                        n_last  = i_head.last;
                        n_scan  = '0;
                        if (!i_head.op && (i_head.data > TTL_LIMIT)) begin
                            n_mode = i_head.last ? M_HDR : M_DROP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_mode == M_PASS) begin
                        // pass a payload byte once the output register frees
                        if (w_load_ok) begin
                            o_pop  = 1'b1;
                            w_load = 1'b1;
                            if (i_head.last) begin
                                n_mode = M_HDR;
                            end
                        end
                    end else begin
                        // drop the rest of a rejected packet
                        o_pop = 1'b1;
                        if (i_head.last) begin
                            n_mode = M_HDR;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_re = w_issue;
                if (w_hit) begin
                    n_mode  = r_last ? M_HDR : M_DROP;
                    n_state = S_IDLE;
                end else if (!w_issue) begin
                    // miss: insert at the replace pointer
                    w_we       = 1'b1;
                    n_wptr     = (r_wptr == SEEN_AW'(SEEN_DEPTH - 1)) ?
                                 '0 : r_wptr + SEEN_AW'(1);
                    n_fill     = (r_fill == FILL_W'(SEEN_DEPTH)) ?
                                 r_fill : r_fill + FILL_W'(1);
                    n_relay_en = r_local ? (r_ttl <= TTL_LIMIT) : (r_ttl != 8'h00);
                    n_idx      = '0;
                    n_state    = S_REPLAY;
                end else begin
                    n_scan = r_scan + FILL_W'(1);
                    n_pend = 1'b1;
                end
            end
            S_REPLAY: begin
                w_ld_dbyte  = w_rep_byte;
                w_ld_rvalid = r_relay_en;
                w_ld_end    = 1'b0;
                if (!r_relay_en) begin
                    w_ld_rbyte = 8'h00;
                end else if ((r_idx == IDX_W'(HDR_LEN - 1)) && !r_local) begin
                    w_ld_rbyte = r_ttl - 8'd1;
                end else begin
                    w_ld_rbyte = w_rep_byte;
                end
                if (w_load_ok) begin
                    w_load = 1'b1;
                    if (r_idx == IDX_W'(HDR_LEN - 1)) begin
                        w_ld_end = r_last;
                        n_mode   = r_last ? M_HDR : M_PASS;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= M_HDR;
            r_fill     <= '0;
            r_wptr     <= '0;
            r_pend     <= 1'b0;
            r_relay_en <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_fill     <= n_fill;
            r_wptr     <= n_wptr;
            r_pend     <= n_pend;
            r_relay_en <= n_relay_en;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // header and scan payload
    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_ttl   <= n_ttl;
        r_local <= n_local;
        r_last  <= n_last;
        r_scan  <= n_scan;
        r_idx   <= n_idx;
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_dbyte  <= w_ld_dbyte;
            r_o_rvalid <= w_ld_rvalid;
            r_o_rbyte  <= w_ld_rbyte;
            r_o_end    <= w_ld_end;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.deliver_valid = 1'b1;
    assign o_out.deliver_byte  = r_o_dbyte;
    assign o_out.relay_valid   = r_o_rvalid;
    assign o_out.relay_byte    = r_o_rbyte;
    assign o_out.end_of_packet = r_o_end;

endmodule

@@ src/mesh_flood_relay_filter.sv @@
// ----------------------------------------------------------------------------
// mesh_flood_relay_filter
// Managed flooding relay with a seen-id cache.
//
//   port    dir  beat carries
//   i_in    in   op, data_byte, last           (one packet byte)
//   o_out   out  deliver_valid, deliver_byte,  (one delivered/relayed byte)
//                relay_valid, relay_byte, end_of_packet
//
// The front takes one input byte per cycle while the 4-entry command queue
// has room. A header is decided by scanning the cache RAM one entry per
// cycle over at most SEEN_DEPTH live entries, then its five bytes leave
// one per cycle while the output is ready, as do payload bytes.
// Reset is synchronous; the cache needs no clearing pass (a fill count marks
// the live entries). Output stalls back up into the queue, then the input.
// ----------------------------------------------------------------------------
module mesh_flood_relay_filter import mfrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfrf_in_if.sink    i_in,
    mfrf_out_if.source o_out
);

    logic    q_push;
    logic    q_pop;
    t_cmd    q_in_cmd;
    t_cmd    q_head;
    t_q_stat q_stat;

    mfrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_cmd    (q_in_cmd)
    );

    mfrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    mfrf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    // never pop an empty queue
    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // never push a full queue
    a_push_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // a byte not relayed carries zero on the relay side
    a_relay_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.relay_valid) |-> (o_out.relay_byte == 8'h00))
        else $error("relay byte nonzero while relay disabled");

    // an input beat reaches the queue only when it could be stored
    a_full_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !i_in.ready)
        else $error("input ready while queue full");

endmodule
